### hw/rtl/umr_pkg.sv
// Shared types and constants for the multi-frame reassembler.
// Depends on nothing; umr_front, umr_back and the core use it by scoped names.
`default_nettype none

package umr_pkg;

   // Result status codes
   localparam logic [3:0] STATUS_BAD_LENGTH  = 4'd0;
   localparam logic [3:0] STATUS_RESYNC_SKIP = 4'd1;
   localparam logic [3:0] STATUS_WRONG_ID    = 4'd2;
   localparam logic [3:0] STATUS_WRONG_TOG   = 4'd3;
   localparam logic [3:0] STATUS_SHORT_FIRST = 4'd4;
   localparam logic [3:0] STATUS_OVERFLOW    = 4'd5;
   localparam logic [3:0] STATUS_APPENDED    = 4'd6;
   localparam logic [3:0] STATUS_DONE_LATCH  = 4'd7;
   localparam logic [3:0] STATUS_DONE_KEPT   = 4'd8;

   localparam int          HEAD_LEN      = 6;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [31:0] TIMEOUT_RESET = 32'd2000;
   localparam int          QUEUE_DEPTH   = 2;

   // Classified frame, as handed from front to back
   typedef struct packed {
      logic                        len_ok;
      logic                        first;
      logic                        last;
      logic                        tog;
      logic [4:0]                  tid;
      logic                        short_first;
      logic [2:0]                  plen;
      logic [15:0]                 crc;
      logic [HEAD_LEN-1:0][7:0]    pay;
      logic [31:0]                 time_ms;
   } frame_type;

   // One result item
   typedef struct packed {
      logic [3:0]  status;
      logic [47:0] payload_latched;
      logic [15:0] transfer_crc;
      logic [4:0]  expected_id;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/umr_fifo.sv
// Small register queue used between the stages and on the result side.
// Depends on nothing; the item travels as a flat vector.
`default_nettype none

module umr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_pop  = pop && !empty;
   assign do_push = push && (!full || do_pop);
   assign rdata   = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/umr_front.sv
// Front stage: checks length, picks the tail byte and aligns the payload.
// Depends on umr_pkg for the classified frame type.
`default_nettype none

module umr_front (
   input  wire logic [3:0]  frame_length,
   input  wire logic [63:0] frame_bytes,
   input  wire logic [31:0] time_ms,
   output umr_pkg::frame_type frame
);

   logic [7:0][7:0] bytes;
   logic [2:0]      len_m1;
   logic [7:0]      tail;

   assign bytes  = frame_bytes;
   assign len_m1 = 3'(frame_length - 4'd1);
   assign tail   = bytes[len_m1];

   // Classify the frame
   always_comb begin
      frame.len_ok      = (frame_length >= 4'd1) && (frame_length <= 4'd8);
      frame.first       = tail[7];
      frame.last        = tail[6];
      frame.tog         = tail[5];
      frame.tid         = tail[4:0];
      frame.short_first = tail[7] && (frame_length < 4'd3);
      frame.plen        = tail[7] ? (len_m1 - 3'd2) : len_m1;
      frame.crc         = frame_bytes[15:0];
      // Start frames carry the CRC first; payload begins at byte two
      frame.pay         = tail[7] ? frame_bytes[63:16] : frame_bytes[47:0];
      frame.time_ms     = time_ms;
   end

endmodule

`default_nettype wire

### hw/rtl/umr_back.sv
// Back stage: holds the reassembly state and updates it one frame a cycle while fire is high.
// Depends on umr_pkg for frame and result types and status codes.
`default_nettype none

module umr_back #(
   parameter int BUF_BYTES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [31:0]        csr_data,
   input  wire logic               fire,
   input  wire umr_pkg::frame_type frame,
   output umr_pkg::result_type     result
);

   localparam int CNT_W = $clog2(BUF_BYTES + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int HL    = umr_pkg::HEAD_LEN;

   logic [31:0]         timeout_ff;
   logic                synced_ff, synced_in;
   logic [4:0]          want_id_ff, want_id_in;
   logic                want_tog_ff, want_tog_in;
   logic [31:0]         last_time_ff, last_time_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [15:0]         crc_ff, crc_in;
   logic [HL-1:0][7:0]  head_ff, head_in;
   logic [HL-1:0][7:0]  latched_ff, latched_in;
   logic [3:0]          status;
   logic                resync;
   logic [2:0]          offset;

   // Work out the next state for one frame
   always_comb begin
      synced_in    = synced_ff;
      want_id_in   = want_id_ff;
      want_tog_in  = want_tog_ff;
      last_time_in = last_time_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      head_in      = head_ff;
      latched_in   = latched_ff;
      status       = umr_pkg::STATUS_BAD_LENGTH;
      resync       = 1'b0;
      offset       = '0;
      if (frame.len_ok) begin
         resync = !synced_ff || ((frame.time_ms - last_time_ff) > timeout_ff) ||
                  (frame.first && (5'(frame.tid - want_id_ff) > 5'd1));
         if (resync) begin
            synced_in   = 1'b1;
            want_id_in  = frame.tid;
            want_tog_in = 1'b0;
            count_in    = '0;
            crc_in      = umr_pkg::CRC_INIT;
         end
         if (resync && !frame.first) begin
            want_id_in = frame.tid + 5'd1;
            status     = umr_pkg::STATUS_RESYNC_SKIP;
         end else if (frame.tid != want_id_in) begin
            status = umr_pkg::STATUS_WRONG_ID;
         end else if (frame.tog != want_tog_in) begin
            status = umr_pkg::STATUS_WRONG_TOG;
         end else begin
            last_time_in = frame.time_ms;
            want_tog_in  = !want_tog_in;
            if (frame.short_first) begin
               status = umr_pkg::STATUS_SHORT_FIRST;
            end else begin
               if (frame.first) begin
                  crc_in = frame.crc;
               end
               if ((SUM_W'(count_in) + SUM_W'(frame.plen)) > SUM_W'(BUF_BYTES)) begin
                  count_in = '0;
                  status   = umr_pkg::STATUS_OVERFLOW;
               end else begin
                  // Drop new bytes into the head window where they land
                  for (int j = 0; j < HL; j++) begin
                     if ((SUM_W'(count_in) <= SUM_W'(j)) &&
                         (SUM_W'(j) < (SUM_W'(count_in) + SUM_W'(frame.plen)))) begin
                        offset     = 3'(SUM_W'(j) - SUM_W'(count_in));
                        head_in[j] = frame.pay[offset];
                     end
                  end
                  count_in = count_in + CNT_W'(frame.plen);
                  if (frame.last) begin
                     if (head_in[0] != 8'd0) begin
                        latched_in = head_in;
                        status     = umr_pkg::STATUS_DONE_LATCH;
                     end else begin
                        status = umr_pkg::STATUS_DONE_KEPT;
                     end
                     count_in    = '0;
                     want_tog_in = 1'b0;
                     want_id_in  = want_id_in + 5'd1;
                     head_in     = '0;
                  end else begin
                     status = umr_pkg::STATUS_APPENDED;
                  end
               end
            end
         end
      end
   end

   // Report from the state after the frame
   assign result.status          = status;
   assign result.payload_latched = latched_in;
   assign result.transfer_crc    = crc_in;
   assign result.expected_id     = want_id_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= umr_pkg::TIMEOUT_RESET;
         synced_ff    <= 1'b0;
         want_id_ff   <= '0;
         want_tog_ff  <= 1'b0;
         last_time_ff <= '0;
         count_ff     <= '0;
         crc_ff       <= umr_pkg::CRC_INIT;
         head_ff      <= '0;
         latched_ff   <= '0;
      end else begin
         if (csr_write) begin
            timeout_ff <= csr_data;
         end
         if (fire) begin
            synced_ff    <= synced_in;
            want_id_ff   <= want_id_in;
            want_tog_ff  <= want_tog_in;
            last_time_ff <= last_time_in;
            count_ff     <= count_in;
            crc_ff       <= crc_in;
            head_ff      <= head_in;
            latched_ff   <= latched_in;
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/uavcan_multiframe_reassembler_core.sv
// Multi-frame transfer reassembler: front classifier, command queue, state
// update stage and result queue. An accepted frame is registered into the
// command queue, and its result into the result queue when the back stage
// takes it. Throughput: one frame per cycle while the result queue has room,
// set by the back stage's state update; the two-entry queues absorb stalls.
// Reset is synchronous: queues empty, state cleared, timeout back to 2000 ms.
`default_nettype none

module uavcan_multiframe_reassembler_core #(
   parameter int BUF_BYTES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [3:0]  req_frame_length,
   input  wire logic [63:0] req_frame_bytes,
   input  wire logic [31:0] req_time_ms,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [3:0]       rsp_status,
   output logic [47:0]      rsp_payload_latched,
   output logic [15:0]      rsp_transfer_crc,
   output logic [4:0]       rsp_expected_id,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   localparam int FRAME_W  = $bits(umr_pkg::frame_type);
   localparam int RESULT_W = $bits(umr_pkg::result_type);

   umr_pkg::frame_type  front_frame, cmd_frame;
   umr_pkg::result_type back_result, rsp_result;
   logic                cmd_empty, cmd_pop;
   logic                rsp_full, rsp_pop_ok;
   logic                req_ok;

   assign csr_ready  = 1'b1;
   assign req_ok     = req_push && !req_full;
   assign rsp_pop_ok = rsp_pop && !rsp_empty;
   // Advance the back stage whenever a frame is waiting and the result queue has room
   assign cmd_pop    = !cmd_empty && (!rsp_full || rsp_pop_ok);

   umr_front u_front (
      .frame_length (req_frame_length),
      .frame_bytes  (req_frame_bytes),
      .time_ms      (req_time_ms),
      .frame        (front_frame)
   );

   umr_fifo #(
      .WIDTH (FRAME_W),
      .DEPTH (umr_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_ok),
      .wdata (front_frame),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (cmd_frame),
      .empty (cmd_empty)
   );

   umr_back #(
      .BUF_BYTES (BUF_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .fire      (cmd_pop),
      .frame     (cmd_frame),
      .result    (back_result)
   );

   umr_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (umr_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_pop),
      .wdata (back_result),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_result),
      .empty (rsp_empty)
   );

   assign rsp_status          = rsp_result.status;
   assign rsp_payload_latched = rsp_result.payload_latched;
   assign rsp_transfer_crc    = rsp_result.transfer_crc;
   assign rsp_expected_id     = rsp_result.expected_id;

`ifndef SYNTH
   // An accepted frame is waiting in the command queue on the next cycle
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_ok |=> !cmd_empty)
      else $error("accepted frame missing from command queue");

   // Each processed frame leaves a result waiting
   a_rsp_lands: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> !rsp_empty)
      else $error("processed frame left no result");

   // A waiting result holds a defined status code
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status <= umr_pkg::STATUS_DONE_KEPT))
      else $error("result status out of range");
`endif

endmodule

`default_nettype wire
